>>> rtl/dmn_pkg.sv
// Shared types, constants and codes for the distributed mutex node.
// Used by dmn_front, dmn_queue, dmn_back and distributed_mutex_node.
package dmn_pkg;

  localparam int MAX_NODES  = 16;
  localparam int CLOCK_BITS = 32;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);

  typedef logic [CLOCK_BITS-1:0] lclk_t;
  typedef logic [MAX_NODES-1:0]  mask_t;

  localparam lclk_t CLK_MAX = '1;

  // Input item kinds.
  localparam logic [1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_MESSAGE = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  // Result actions.
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_REQUEST = 2'd1;
  localparam logic [1:0] ACT_OK      = 2'd2;
  localparam logic [1:0] ACT_GRANT   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_NODE_ID    = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  dest;
    logic [31:0] clock;
  } res_t;

  // One classified request as handed from the front to the back: up to two
  // single results, then an OK to every node set in walk_mask.
  typedef struct packed {
    logic  res0_v;
    res_t  res0;
    logic  res1_v;
    res_t  res1;
    mask_t walk_mask;
    lclk_t walk_clock;
  } job_t;

  function automatic lclk_t clk_inc(input lclk_t v);
    clk_inc = (v == CLK_MAX) ? v : v + lclk_t'(1);
  endfunction

endpackage

>>> rtl/dmn_front.sv
// Front end of the distributed mutex node: configuration registers, Lamport
// clock, phase and masks; classifies each request into a job. Uses dmn_pkg.
module dmn_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         in_kind,
  input  logic               in_msg_is_request,
  input  logic [31:0]        in_msg_clock,
  input  logic [3:0]         in_msg_sender,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data,
  output logic               push,
  output dmn_pkg::job_t      job
);

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_CRIT} phase_t;

  phase_t                phase_r, phase_nxt;
  dmn_pkg::lclk_t        clock_r, clock_nxt;
  dmn_pkg::lclk_t        stamp_r, stamp_nxt;
  dmn_pkg::mask_t        conf_r, conf_nxt;
  dmn_pkg::mask_t        def_r, def_nxt;
  logic [3:0]            node_id_r;
  logic [4:0]            node_count_r;

  dmn_pkg::lclk_t        mclk;
  dmn_pkg::lclk_t        msg_clk_new;
  dmn_pkg::mask_t        bit_s;
  dmn_pkg::mask_t        self_bit;
  logic [4:0]            needed;
  logic [dmn_pkg::CNT_W-1:0] pop_new, pop_cur;
  logic                  sender_ok;
  logic                  we_win;

  function automatic logic [dmn_pkg::CNT_W-1:0] popcnt(input dmn_pkg::mask_t m);
    logic [dmn_pkg::CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < dmn_pkg::MAX_NODES; i++) begin
      c = c + dmn_pkg::CNT_W'(m[i]);
    end
    popcnt = c;
  endfunction

  always_comb begin
    if ({32'd0, in_msg_clock} > 64'(dmn_pkg::CLK_MAX)) begin
      mclk = dmn_pkg::CLK_MAX;
    end else begin
      mclk = dmn_pkg::CLOCK_BITS'(in_msg_clock);
    end
    msg_clk_new = dmn_pkg::clk_inc((clock_r > mclk) ? clock_r : mclk);
    bit_s     = dmn_pkg::mask_t'(1) << in_msg_sender;
    self_bit  = dmn_pkg::mask_t'(1) << node_id_r;
    sender_ok = (in_msg_sender != node_id_r) && (int'(in_msg_sender) < dmn_pkg::MAX_NODES);
    if (node_count_r < 5'd2) begin
      needed = 5'd1;
    end else if (int'(node_count_r) > dmn_pkg::MAX_NODES) begin
      needed = 5'(dmn_pkg::MAX_NODES - 1);
    end else begin
      needed = node_count_r - 5'd1;
    end
  end

  // Decision logic for one accepted request.
  always_comb begin
    phase_nxt = phase_r;
    clock_nxt = clock_r;
    stamp_nxt = stamp_r;
    conf_nxt  = conf_r;
    def_nxt   = def_r;
    job       = '0;
    pop_cur   = popcnt(conf_r);
    pop_new   = '0;
    we_win    = 1'b0;
    if (accept) begin
      case (in_kind)
        dmn_pkg::KIND_ACQUIRE: begin
          if (phase_r == PH_IDLE) begin
            clock_nxt         = dmn_pkg::clk_inc(clock_r);
            stamp_nxt         = clock_nxt;
            conf_nxt          = '0;
            phase_nxt         = PH_WAIT;
            job.res0_v        = 1'b1;
            job.res0.action   = dmn_pkg::ACT_REQUEST;
            job.res0.clock    = 32'(clock_nxt);
          end
        end
        dmn_pkg::KIND_RELEASE: begin
          if (phase_r == PH_CRIT) begin
            clock_nxt      = dmn_pkg::clk_inc(clock_r);
            job.walk_mask  = def_r & ~self_bit;
            job.walk_clock = clock_nxt;
            def_nxt        = '0;
            conf_nxt       = '0;
            phase_nxt      = PH_IDLE;
          end
        end
        dmn_pkg::KIND_MESSAGE: begin
          if (sender_ok) begin
            clock_nxt = msg_clk_new;
            case (phase_r)
              PH_WAIT: begin
                if (!in_msg_is_request) begin
                  conf_nxt = conf_r | bit_s;
                end else if ((conf_r & bit_s) != '0) begin
                  def_nxt = def_r | bit_s;
                end else begin
                  // Our pending request is older (or wins the id tie): defer.
                  we_win = (stamp_r < mclk) ||
                           ((stamp_r == mclk) && (node_id_r < in_msg_sender));
                  if (we_win) begin
                    conf_nxt = conf_r | bit_s;
                    def_nxt  = def_r | bit_s;
                  end else begin
                    job.res0_v      = 1'b1;
                    job.res0.action = dmn_pkg::ACT_OK;
                    job.res0.dest   = in_msg_sender;
                    job.res0.clock  = 32'(msg_clk_new);
                  end
                end
                pop_new = popcnt(conf_nxt);
                if (5'(pop_new) >= needed) begin
                  phase_nxt       = PH_CRIT;
                  job.res1_v      = 1'b1;
                  job.res1.action = dmn_pkg::ACT_GRANT;
                  job.res1.clock  = 32'(msg_clk_new);
                end
              end
              PH_CRIT: begin
                if (in_msg_is_request) begin
                  def_nxt = def_r | bit_s;
                end
              end
              default: begin
                if (in_msg_is_request) begin
                  job.res0_v      = 1'b1;
                  job.res0.action = dmn_pkg::ACT_OK;
                  job.res0.dest   = in_msg_sender;
                  job.res0.clock  = 32'(msg_clk_new);
                end
              end
            endcase
          end
        end
        default: begin
          if (phase_r == PH_WAIT) begin
            job.res0_v = 1'b1;
            if (5'(pop_cur) >= needed) begin
              phase_nxt       = PH_CRIT;
              job.res0.action = dmn_pkg::ACT_GRANT;
              job.res0.clock  = 32'(clock_r);
            end else begin
              job.res0.action = dmn_pkg::ACT_REQUEST;
              job.res0.clock  = 32'(stamp_r);
            end
          end
        end
      endcase
    end
    push = job.res0_v || job.res1_v || (job.walk_mask != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      clock_r      <= '0;
      stamp_r      <= '0;
      conf_r       <= '0;
      def_r        <= '0;
      node_id_r    <= 4'd0;
      node_count_r <= 5'd2;
    end else begin
      phase_r <= phase_nxt;
      clock_r <= clock_nxt;
      stamp_r <= stamp_nxt;
      conf_r  <= conf_nxt;
      def_r   <= def_nxt;
      if (cfg_we) begin
        case (cfg_index)
          dmn_pkg::CFG_NODE_ID:    node_id_r    <= cfg_data[3:0];
          dmn_pkg::CFG_NODE_COUNT: node_count_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> rtl/dmn_queue.sv
// Two-entry job queue between the front and back of the mutex node.
// Uses dmn_pkg for the job type.
module dmn_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dmn_pkg::job_t push_job,
  input  logic          pop,
  output logic          head_valid,
  output dmn_pkg::job_t head_job,
  output logic          full
);

  dmn_pkg::job_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  assign head_valid = (count_r != 2'd0);
  assign full       = (count_r == 2'd2);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/dmn_back.sv
// Back end of the mutex node: takes jobs from the queue and emits their
// results one per cycle, walking the OK fan-out mask. Uses dmn_pkg.
module dmn_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  dmn_pkg::job_t head_job,
  output logic          pop,
  output logic          out_strobe,
  output logic [1:0]    out_action,
  output logic [3:0]    out_dest_node,
  output logic [31:0]   out_clock,
  output logic          out_last
);

  logic           active_r;
  logic           p0_r, p1_r;
  dmn_pkg::res_t  r0_r, r1_r;
  dmn_pkg::mask_t mask_r;
  dmn_pkg::lclk_t wclk_r;

  logic           strobe_r;
  dmn_pkg::res_t  res_r;
  logic           last_r;

  dmn_pkg::res_t  emit;
  logic           emit_last;
  logic [dmn_pkg::NODE_W-1:0] low_idx;
  dmn_pkg::mask_t mask_rest;
  logic           load;

  function automatic logic [dmn_pkg::NODE_W-1:0] lowest(input dmn_pkg::mask_t m);
    logic [dmn_pkg::NODE_W-1:0] idx;
    idx = '0;
    for (int i = dmn_pkg::MAX_NODES - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = dmn_pkg::NODE_W'(i);
      end
    end
    lowest = idx;
  endfunction

  always_comb begin
    low_idx   = lowest(mask_r);
    mask_rest = mask_r & ~(dmn_pkg::mask_t'(1) << low_idx);
    emit      = '0;
    emit_last = 1'b0;
    if (p0_r) begin
      emit      = r0_r;
      emit_last = !p1_r && (mask_r == '0);
    end else if (p1_r) begin
      emit      = r1_r;
      emit_last = (mask_r == '0);
    end else begin
      emit.action = dmn_pkg::ACT_OK;
      emit.dest   = 4'(low_idx);
      emit.clock  = 32'(wclk_r);
      emit_last   = (mask_rest == '0);
    end
    load = (!active_r || emit_last) && head_valid;
    pop  = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
      p0_r     <= 1'b0;
      p1_r     <= 1'b0;
      mask_r   <= '0;
    end else begin
      strobe_r <= active_r;
      last_r   <= active_r && emit_last;
      if (active_r) begin
        res_r <= emit;
        if (p0_r) begin
          p0_r <= 1'b0;
        end else if (p1_r) begin
          p1_r <= 1'b0;
        end else begin
          mask_r <= mask_rest;
        end
      end
      if (load) begin
        active_r <= 1'b1;
        p0_r     <= head_job.res0_v;
        p1_r     <= head_job.res1_v;
        r0_r     <= head_job.res0;
        r1_r     <= head_job.res1;
        mask_r   <= head_job.walk_mask;
        wclk_r   <= head_job.walk_clock;
      end else if (active_r && emit_last) begin
        active_r <= 1'b0;
      end
    end
  end

  assign out_strobe    = strobe_r;
  assign out_action    = res_r.action;
  assign out_dest_node = res_r.dest;
  assign out_clock     = res_r.clock;
  assign out_last      = last_r;

endmodule

>>> rtl/distributed_mutex_node.sv
// Distributed mutex node: one participant of Ricart-Agrawala mutual exclusion.
// A request's job is written into the job queue, loaded into the back end's job
// registers and then into its output registers, which drive the result ports.
// Throughput: one result per cycle from the back end; a request with n results
// holds the back end until all n are out (a release fans out up to fifteen OKs).
// busy is high while the two-entry job queue is full. Synchronous active-low
// reset clears the clock, phase, masks, queue and config (node_id 0, count 2).
module distributed_mutex_node (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic        in_msg_is_request,
  input  logic [31:0] in_msg_clock,
  input  logic [3:0]  in_msg_sender,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        out_strobe,
  output logic [1:0]  out_action,
  output logic [3:0]  out_dest_node,
  output logic [31:0] out_clock,
  output logic        out_last
);

  // The front end applies every state change in the cycle a request is
  // taken, so later requests see up-to-date clock and masks while the back
  // end is still emitting results of earlier ones. Results leave in the
  // order the jobs were queued.
  logic          accept;
  logic          push;
  dmn_pkg::job_t push_job;
  logic          pop;
  logic          head_valid;
  dmn_pkg::job_t head_job;
  logic          q_full;

  assign busy   = q_full;
  assign accept = start && !q_full;

  dmn_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .in_kind           (in_kind),
    .in_msg_is_request (in_msg_is_request),
    .in_msg_clock      (in_msg_clock),
    .in_msg_sender     (in_msg_sender),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .job               (push_job)
  );

  // Requests that cause no result never enter the queue.
  dmn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .full       (q_full)
  );

  // The back end emits one result per cycle; the receiver cannot stall it.
  dmn_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_strobe    (out_strobe),
    .out_action    (out_action),
    .out_dest_node (out_dest_node),
    .out_clock     (out_clock),
    .out_last      (out_last)
  );

endmodule
